[hdl/gpyr_pkg.sv]
// shared constants, register indexes and types of the gaussian pyramid reduce block
`default_nettype none

package gpyr_pkg;

  // field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned LINE_W     = 12;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned CMP_W      = 14;
  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_IDX_W = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROW_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ROW_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ROW_CNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EVEN_R = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EVEN_C = 3'd4;

  // register reset values
  localparam logic [CNT_W-1:0] SRC_ROW_LEN_RST = 13'd1284;
  localparam logic [DIM_W-1:0] DST_ROW_LEN_RST = 12'd640;
  localparam logic [DIM_W-1:0] DST_ROW_CNT_RST = 12'd480;

  // row counter saturates here
  localparam logic [CNT_W-1:0] ROW_CNT_MAX = 13'h1FFF;

  // per-pixel request handed to the line store stage
  typedef struct packed {
    logic [LANE_IDX_W-1:0] lane;  // slot of the current row
    logic                  wr;    // horizontal sum goes to the store
    logic                  emit;  // a result pixel is produced
    logic                  re;    // last pixel of an output row
    logic                  fe;    // last pixel of the frame
    logic [LINE_W-1:0]     h;     // horizontal 1-4-6-4-1 sum
  } gpyr_req_t;

endpackage

`default_nettype wire

[hdl/gpyr_if.sv]
// stream interfaces for source pixels and reduced pixels
`default_nettype none

interface gpyr_in_if
  import gpyr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface gpyr_out_if
  import gpyr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

`default_nettype wire

[hdl/gpyr_vfilt.sv]
// line store memory with read-modify-write of one slot and the vertical filter sum
`default_nettype none

module gpyr_vfilt
  import gpyr_pkg::*;
#(
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire gpyr_req_t                req_i,
  input  wire logic                     wr_go_i,
  output gpyr_req_t                     ctl_o,
  output logic [SUM_W-1:0]              sum_o
);

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned WORD_W = LANES * LINE_W;

  // one word per kept column, one lane per line slot
  logic [WORD_W-1:0] mem [DEPTH];

  logic [WORD_W-1:0] rd_q;
  logic [AW-1:0]     addr_q;
  gpyr_req_t         req_q;
  logic [WORD_W-1:0] wr_word;

  // read on transaction, request held alongside the read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q   <= mem[addr_i];
      addr_q <= addr_i;
      req_q  <= req_i;
    end
  end

  // merge the new horizontal sum into its lane
  always_comb begin
    wr_word = rd_q;
    wr_word[req_q.lane*LINE_W +: LINE_W] = req_q.h;
  end

  // write back once the stage moves on
  always_ff @(posedge clk_i) begin
    if (wr_go_i && req_q.wr) begin
      mem[addr_q] <= wr_word;
    end
  end

  // vertical 1-4-6-4-1 over the four stored rows and the current one
  always_comb begin
    logic [LANE_IDX_W-1:0] l1, l2, l3;
    logic [SUM_W-1:0]      a, b, c, d;
    l1 = req_q.lane + LANE_IDX_W'(1);
    l2 = req_q.lane + LANE_IDX_W'(2);
    l3 = req_q.lane + LANE_IDX_W'(3);
    a  = SUM_W'(rd_q[req_q.lane*LINE_W +: LINE_W]);
    b  = SUM_W'(rd_q[l1*LINE_W +: LINE_W]);
    c  = SUM_W'(rd_q[l2*LINE_W +: LINE_W]);
    d  = SUM_W'(rd_q[l3*LINE_W +: LINE_W]);
    sum_o = a + (b << 2) + (c << 2) + (c << 1) + (d << 2) + SUM_W'(req_q.h);
  end

  assign ctl_o = req_q;

endmodule

`default_nettype wire

[hdl/gaussian_pyramid_half_scale_top.sv]
// Gaussian pyramid 5x5 reduce: source pixels in raster order in, half-scale pixels out.
// Channels: in_i takes one source pixel per transaction with frame_start on the first
// pixel of a frame; out_o gives one reduced pixel per transaction with row_end and
// frame_end flags. Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
// while the block is idle.
// Throughput: one source pixel per cycle, sustained, with both channels free.
// Path: a result passes the line store read register and then the output register after the
// transaction of the pixel that completes its window.
// The four line slots share one memory word per kept column; every accepted pixel reads
// its word once and a pixel on a kept column writes it back when the stage moves on, so
// the single read port and single write port set the one-pixel-per-cycle figure.
// Reset: counters, the pixel taps and the pipeline valid bits clear, registers take
// their reset values; the line store is not cleared and needs no clearing pass,
// since every entry is written by the first rows of a frame before it is read.
// Stall: when out_o.ready is low a finished result waits in the output register;
// pixels that finish no window keep flowing, and the next pixel that finishes one waits
// in the line store stage and holds off in_i.ready until the output drains.
`default_nettype none

module gaussian_pyramid_half_scale_top
  import gpyr_pkg::*;
#(
  parameter int unsigned MAX_DST_WIDTH = 2048
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  gpyr_in_if.sink                    in_i,
  gpyr_out_if.source                 out_o
);

  localparam int unsigned AW = $clog2(MAX_DST_WIDTH);
  localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_DST_WIDTH);

  // configuration registers
  logic [CNT_W-1:0] src_row_length_q;
  logic [DIM_W-1:0] dst_row_length_q;
  logic [DIM_W-1:0] dst_row_count_q;
  logic             keep_even_rows_q;
  logic             keep_even_columns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_row_length_q    <= SRC_ROW_LEN_RST;
      dst_row_length_q    <= DST_ROW_LEN_RST;
      dst_row_count_q     <= DST_ROW_CNT_RST;
      keep_even_rows_q    <= 1'b1;
      keep_even_columns_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_ROW_LEN: src_row_length_q    <= cfg_data_i[CNT_W-1:0];
        CFG_DST_ROW_LEN: dst_row_length_q    <= cfg_data_i[DIM_W-1:0];
        CFG_DST_ROW_CNT: dst_row_count_q     <= cfg_data_i[DIM_W-1:0];
        CFG_KEEP_EVEN_R: keep_even_rows_q    <= cfg_data_i[0];
        CFG_KEEP_EVEN_C: keep_even_columns_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake state
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             in_acc;
  logic             s1_adv;
  logic             out_free;
  gpyr_req_t        s1_ctl;
  logic [SUM_W-1:0] s1_sum;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = !s1_ctl.emit || out_free;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // pixel taps and position counters
  logic [PIX_W-1:0] win_q [LANES];
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;

  gpyr_req_t        req;
  logic [AW-1:0]    addr;

  // window position, horizontal sum and counter update for the incoming pixel
  always_comb begin
    logic [CNT_W-1:0]  c, r, cx, ry;
    logic [CMP_W-1:0]  lim, x;
    logic [CNT_W-1:0]  y;
    logic              co, ro, col_ok, row_ok, x_ok, y_ok;
    logic [CMP_W-1:0]  c_nx;
    co   = !keep_even_columns_q;
    ro   = !keep_even_rows_q;
    c    = in_i.frame_start ? '0 : col_q;
    r    = in_i.frame_start ? '0 : row_q;
    lim  = (CMP_W'(dst_row_length_q) < MAX_W) ? CMP_W'(dst_row_length_q) : MAX_W;

    cx     = c - CNT_W'(4) - CNT_W'(co);
    col_ok = (c >= CNT_W'(4) + CNT_W'(co)) && (c[0] == co);
    x      = CMP_W'(cx[CNT_W-1:1]);
    x_ok   = x < lim;

    ry     = r - CNT_W'(4) - CNT_W'(ro);
    row_ok = (r >= CNT_W'(4) + CNT_W'(ro)) && (r[0] == ro);
    y      = CNT_W'(ry[CNT_W-1:1]);
    y_ok   = y < CNT_W'(dst_row_count_q);

    req.lane = r[LANE_IDX_W-1:0];
    req.wr   = col_ok && x_ok;
    req.emit = col_ok && x_ok && row_ok && y_ok;
    req.re   = (x + CMP_W'(1)) == lim;
    req.fe   = req.re && ((y + CNT_W'(1)) == CNT_W'(dst_row_count_q));
    req.h    = LINE_W'(win_q[3]) + (LINE_W'(win_q[2]) << 2) + (LINE_W'(win_q[1]) << 2)
             + (LINE_W'(win_q[1]) << 1) + (LINE_W'(win_q[0]) << 2)
             + LINE_W'(in_i.pixel_in);
    addr     = x[AW-1:0];

    c_nx = CMP_W'(c) + CMP_W'(1);
    if (c_nx >= CMP_W'(src_row_length_q)) begin
      col_d = '0;
      row_d = (r != ROW_CNT_MAX) ? r + CNT_W'(1) : r;
    end else begin
      col_d = c_nx[CNT_W-1:0];
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < LANES; i++) begin
        win_q[i] <= '0;
      end
    end else if (in_acc) begin
      col_q    <= col_d;
      row_q    <= row_d;
      win_q[0] <= in_i.pixel_in;
      for (int i = 1; i < LANES; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // line store and vertical filter stage
  gpyr_vfilt #(
    .DEPTH (MAX_DST_WIDTH)
  ) u_vfilt (
    .clk_i   (clk_i),
    .rd_en_i (in_acc),
    .addr_i  (addr),
    .req_i   (req),
    .wr_go_i (s1_valid_q && s1_adv),
    .ctl_o   (s1_ctl),
    .sum_o   (s1_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // output register
  logic [PIX_W-1:0] pix_q;
  logic             re_q;
  logic             fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_ctl.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ctl.emit && out_free) begin
      pix_q <= s1_sum[SUM_W-1:SUM_W-PIX_W];
      re_q  <= s1_ctl.re;
      fe_q  <= s1_ctl.fe;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = pix_q;
  assign out_o.row_end   = re_q;
  assign out_o.frame_end = fe_q;

endmodule

`default_nettype wire

[hdl/gpyr_checker.sv]
// port-level checks of the gaussian pyramid reduce block and their bind
`default_nettype none

module gpyr_checker
  import gpyr_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [PIX_W-1:0] pixel_out_i,
  input wire logic             row_end_i,
  input wire logic             frame_end_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result keeps valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(pixel_out_i) && $stable(row_end_i) && $stable(frame_end_i))
    else $error("result payload changed while stalled");

  // the last pixel of a frame also closes its row
  a_fe_re: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> row_end_i)
    else $error("frame end without row end");

  // a fresh result comes from an input transaction through the line store stage with no wait
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("result without a matching input transaction");

endmodule

bind gaussian_pyramid_half_scale_top gpyr_checker u_gpyr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pixel_out_i (out_o.pixel_out),
  .row_end_i   (out_o.row_end),
  .frame_end_i (out_o.frame_end)
);

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench of the gaussian pyramid half-scale reduce block
module testbench;
  import gpyr_pkg::*;

  localparam int unsigned MAX_W = 2048;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } src_pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } reduced_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gpyr_in_if  src_ch ();
  gpyr_out_if dst_ch ();

  gaussian_pyramid_half_scale_top #(
    .MAX_DST_WIDTH(MAX_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (src_ch.sink),
    .out_o     (dst_ch.source)
  );

  // mirror of the block state and registers
  bit [CNT_W-1:0]  src_len;
  bit [DIM_W-1:0]  dst_len;
  bit [DIM_W-1:0]  dst_cnt;
  bit              keep_rows;
  bit              keep_cols;
  bit [LINE_W-1:0] hsum_mem [4*MAX_W];
  bit [PIX_W-1:0]  taps [4];
  bit [CNT_W-1:0]  col_cnt;
  bit [CNT_W-1:0]  row_cnt;

  src_pixel_t pixel_backlog [$];
  reduced_t   reduced_expected [$];
  src_pixel_t next_px;
  reduced_t   want;

  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int unsigned pixels_reduced;
  int unsigned mismatches;
  int unsigned settings_used;
  int unsigned send_gap;
  int unsigned stall_left;
  bit          quiet;

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // expected results for one source pixel
  function automatic void reduce_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned r, c, x, y, lim, h, s, ro, co;
    reduced_t res;
    ro = keep_rows ? 0 : 1;
    co = keep_cols ? 0 : 1;
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    r = row_cnt;
    c = col_cnt;
    lim = (dst_len < MAX_W) ? dst_len : MAX_W;
    // horizontal window ends here on a kept column
    if (c >= 4 + co && ((c - 4 - co) % 2) == 0) begin
      x = (c - 4 - co) / 2;
      if (x < lim) begin
        h = taps[3] + 4 * taps[2] + 6 * taps[1] + 4 * taps[0] + pix;
        if (r >= 4 + ro && ((r - 4 - ro) % 2) == 0) begin
          y = (r - 4 - ro) / 2;
          if (y < dst_cnt) begin
            s = hsum_mem[(r % 4) * MAX_W + x]
              + 4 * hsum_mem[((r + 1) % 4) * MAX_W + x]
              + 6 * hsum_mem[((r + 2) % 4) * MAX_W + x]
              + 4 * hsum_mem[((r + 3) % 4) * MAX_W + x] + h;
            res.pixel     = s[15:8];
            res.row_end   = (x + 1 == lim);
            res.frame_end = res.row_end && (y + 1 == dst_cnt);
            reduced_expected.push_back(res);
          end
        end
        hsum_mem[(r % 4) * MAX_W + x] = h[LINE_W-1:0];
      end
    end
    taps[3] = taps[2];
    taps[2] = taps[1];
    taps[1] = taps[0];
    taps[0] = pix;
    // row wrap with saturating row counter
    if (c + 1 >= src_len) begin
      col_cnt = '0;
      if (row_cnt < ROW_CNT_MAX) row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = CNT_W'(c + 1);
    end
  endfunction

  // source side: feed pending pixels with random idle bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      src_ch.valid <= 1'b0;
    end else if (!src_ch.valid || src_ch.ready) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        src_ch.valid <= 1'b0;
      end else if (!quiet && pixel_backlog.size() > 0 && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 18);
        src_ch.valid <= 1'b0;
      end else if (pixel_backlog.size() > 0) begin
        next_px = pixel_backlog.pop_front();
        src_ch.valid       <= 1'b1;
        src_ch.pixel_in    <= next_px.pixel;
        src_ch.frame_start <= next_px.frame_start;
      end else begin
        src_ch.valid <= 1'b0;
      end
    end
  end

  // result side: ready with random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dst_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      dst_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(0, 18);
      dst_ch.ready <= 1'b0;
    end else begin
      dst_ch.ready <= 1'b1;
    end
  end

  // monitor: predict on each input transaction, check each output transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src_ch.valid && src_ch.ready) begin
        reduce_pixel(src_ch.pixel_in, src_ch.frame_start);
        pixels_taken++;
      end
      if (dst_ch.valid && dst_ch.ready) begin
        pixels_reduced++;
        if (reduced_expected.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, actual pixel %0d re %0b fe %0b",
                   $time, dst_ch.pixel_out, dst_ch.row_end, dst_ch.frame_end);
        end else begin
          want = reduced_expected.pop_front();
          if (dst_ch.pixel_out !== want.pixel) begin
            mismatches++;
            $display("%0t pixel_out mismatch: expected %0d actual %0d",
                     $time, want.pixel, dst_ch.pixel_out);
          end
          if (dst_ch.row_end !== want.row_end) begin
            mismatches++;
            $display("%0t row_end mismatch: expected %0b actual %0b",
                     $time, want.row_end, dst_ch.row_end);
          end
          if (dst_ch.frame_end !== want.frame_end) begin
            mismatches++;
            $display("%0t frame_end mismatch: expected %0b actual %0b",
                     $time, want.frame_end, dst_ch.frame_end);
          end
        end
      end
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    pixel_backlog.push_back('{pixel: pix, frame_start: fs});
    pixels_queued++;
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // one register write, mirrored in the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_SRC_ROW_LEN: src_len = val[CNT_W-1:0];
      CFG_DST_ROW_LEN: dst_len = val[DIM_W-1:0];
      CFG_DST_ROW_CNT: dst_cnt = val[DIM_W-1:0];
      CFG_KEEP_EVEN_R: keep_rows = val[0];
      CFG_KEEP_EVEN_C: keep_cols = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned src, input int unsigned dlen,
                              input int unsigned dcnt, input bit kr, input bit kc);
    write_reg(CFG_SRC_ROW_LEN, src);
    write_reg(CFG_DST_ROW_LEN, dlen);
    write_reg(CFG_DST_ROW_CNT, dcnt);
    write_reg(CFG_KEEP_EVEN_R, kr);
    write_reg(CFG_KEEP_EVEN_C, kc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // whole rows of random pixels, optionally cut short
  task automatic send_frame(input int unsigned rows, input bit truncate);
    int unsigned total, n;
    total = rows * src_len;
    if (truncate && total > 1) total = $urandom_range(1, total - 1);
    for (n = 0; n < total; n++) push_pixel(random_pixel(), n == 0);
  endtask

  // all transactions done and the pipeline flushed
  task automatic wait_drained();
    while (pixels_taken != pixels_queued || reduced_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int unsigned n, r, c, co, fit, frames, rows, rand_items;
    bit kr, kc;
    int unsigned dlen, dcnt, src;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    src_ch.valid       = 1'b0;
    src_ch.pixel_in    = '0;
    src_ch.frame_start = 1'b0;
    dst_ch.ready       = 1'b0;
    send_gap   = 0;
    stall_left = 0;
    quiet      = 1'b0;
    src_len   = SRC_ROW_LEN_RST;
    dst_len   = DST_ROW_LEN_RST;
    dst_cnt   = DST_ROW_CNT_RST;
    keep_rows = 1'b1;
    keep_cols = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short rows, every other register left at its reset value
    write_reg(CFG_SRC_ROW_LEN, 12);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_frame(5, 1'b0);
    wait_drained();

    // smallest window: a 5x5 checkerboard of both extremes
    set_geometry(5, 1, 1, 1'b1, 1'b1);
    for (r = 0; r < 5; r++)
      for (c = 0; c < 5; c++) push_pixel(((r + c) % 2) ? 8'hFF : 8'h00, r == 0 && c == 0);
    wait_drained();

    // zero row length and zero row count give nothing
    set_geometry(9, 0, 2, 1'b1, 1'b0);
    send_frame(6, 1'b0);
    wait_drained();
    set_geometry(9, 2, 0, 1'b0, 1'b1);
    send_frame(6, 1'b0);
    wait_drained();

    // degenerate row lengths, no column ever qualifies
    set_geometry(0, 3, 3, 1'b1, 1'b1);
    for (n = 0; n < 40; n++) push_pixel(random_pixel(), n == 0 || n == 17);
    wait_drained();
    set_geometry(1, 3, 3, 1'b0, 1'b0);
    for (n = 0; n < 40; n++) push_pixel(random_pixel(), n == 0);
    wait_drained();

    // row length register above the store width
    set_geometry(24, 4095, 1, 1'b1, 1'b0);
    send_frame(5, 1'b0);
    wait_drained();

    // random geometries and frames, with broken frames and stray pixels
    rand_items = 0;
    while (rand_items < 260) begin
      if (rand_items >= 200) quiet = 1'b1;
      src = $urandom_range(5, 32);
      kr  = 1'($urandom_range(0, 1));
      kc  = 1'($urandom_range(0, 1));
      co  = kc ? 0 : 1;
      fit = (src >= 5 + co) ? (src - 5 - co) / 2 + 1 : 0;
      case ($urandom_range(0, 9))
        0:       dlen = 0;
        1, 2:    dlen = fit + $urandom_range(1, 3);
        default: dlen = $urandom_range(1, (fit > 0) ? fit : 1);
      endcase
      case ($urandom_range(0, 9))
        0:       dcnt = 0;
        1:       dcnt = 4095;
        default: dcnt = $urandom_range(1, 3);
      endcase
      set_geometry(src, dlen, dcnt, kr, kc);
      frames = $urandom_range(1, 3);
      for (n = 0; n < frames; n++) begin
        if (dcnt >= 1 && dcnt <= 3) rows = 5 + (kr ? 0 : 1) + 2 * (dcnt - 1);
        else rows = $urandom_range(3, 9);
        r = pixels_queued;
        send_frame(rows, $urandom_range(0, 5) == 0);
        rand_items += pixels_queued - r;
      end
      if ($urandom_range(0, 3) == 0) begin
        c = $urandom_range(1, 12);
        for (n = 0; n < c; n++) push_pixel(random_pixel(), $urandom_range(0, 7) == 0);
        rand_items += c;
      end
      wait_drained();
    end

    $display("ran %0d source pixels over %0d register settings", pixels_taken, settings_used);
    $display("checked %0d reduced pixels, %0d mismatches", pixels_reduced, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
